// ===== design/fbpa_pkg.sv =====
package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = 8;
  localparam int LINK_W     = 9;
  localparam int SPAN_W     = 26;
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_BLOCKS);

  // register indexes of the configuration channel
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic [31:0] BASE_RST  = 32'd4096;
  localparam logic [16:0] SIZE_RST  = 17'd64;
  localparam logic [8:0]  COUNT_RST = 9'd256;
  localparam logic [16:0] SIZE_MIN  = 17'd8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_NULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_MISALIGN  = 3'd4,
    ST_DOUBLE    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_NULL  = 2'd1,
    K_FREE  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
  } item_t;

  // effective pool geometry
  typedef struct packed {
    logic [31:0]       base;
    logic [16:0]       size;
    logic [8:0]        count;
    logic [SPAN_W-1:0] span;
  } geom_t;

  typedef struct packed {
    logic       valid;
    logic [8:0] count;
  } rethread_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_ADDR,
    S_DIV,
    S_WALK,
    S_WALK_WAIT,
    S_PUSH,
    S_DONE
  } state_t;

  function automatic logic [16:0] eff_size(input logic [16:0] s);
    return (s < SIZE_MIN) ? SIZE_MIN : s;
  endfunction

  function automatic logic [8:0] eff_count(input logic [8:0] c);
    logic [8:0] r;
    r = c;
    if (c == 9'd0) r = 9'd1;
    else if (c > COUNT_RST) r = COUNT_RST;
    return r;
  endfunction

endpackage

// ===== design/fbpa_ram.sv =====
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fbpa_front.sv =====
module fbpa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,
  input  logic [0:0]     s_tuser,
  output logic           q_valid,
  output fbpa_pkg::item_t q_item,
  input  logic           q_pop
);
  import fbpa_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  item_t      incoming;
  logic       push;

  // classify the request
  always_comb begin
    incoming.address = s_tdata;
    if (s_tuser[0] == 1'b0) incoming.kind = K_ALLOC;
    else if (s_tdata == 32'd0) incoming.kind = K_NULL;
    else incoming.kind = K_FREE;
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= incoming;
  end

endmodule

// ===== design/fbpa_back.sv =====
module fbpa_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  fbpa_pkg::item_t     q_item,
  output logic                q_pop,
  input  fbpa_pkg::geom_t     geom,
  input  fbpa_pkg::rethread_t rethr,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata
);
  import fbpa_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [LINK_W-1:0]  head;
  logic [8:0]         free_total;
  logic [IDX_W-1:0]   work_idx;
  logic [LINK_W-1:0]  cur;
  logic [8:0]         steps;
  logic [SPAN_W-1:0]  rem;
  logic [2:0]         div_k;
  logic [25:0]        prod;
  status_t            res_status;
  logic [31:0]        res_addr;
  logic [MAX_BLOCKS-1:0] written;

  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   rd_addr_q;
  logic [LINK_W-1:0]  ram_q;
  logic [LINK_W-1:0]  link_dflt;
  logic [LINK_W-1:0]  link_rd;
  logic               ram_we;
  logic               out_free;

  logic [32:0]        pool_end;
  logic               out_range;
  logic [SPAN_W-1:0]  trial;
  logic               ge;
  logic [SPAN_W-1:0]  rem_nx;
  logic               walk_end;

  // link table
  fbpa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BLOCKS)) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (work_idx),
    .wdata (head),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign rd_addr = (state == S_IDLE) ? head[IDX_W-1:0] : cur[IDX_W-1:0];

  // never-written entries read as the threaded default
  assign link_dflt = ((LINK_W'(rd_addr_q) + 9'd1) < geom.count) ?
                     (LINK_W'(rd_addr_q) + 9'd1) : NIL_LINK;
  assign link_rd   = written[rd_addr_q] ? ram_q : link_dflt;

  // range and alignment helpers
  assign pool_end  = {1'b0, geom.base} + 33'(geom.span);
  assign out_range = (q_item.address < geom.base) || ({1'b0, q_item.address} >= pool_end);
  assign trial     = SPAN_W'(geom.size) << div_k;
  assign ge        = (rem >= trial);
  assign rem_nx    = ge ? (rem - trial) : rem;
  assign walk_end  = cur[IDX_W] || (steps == 9'(MAX_BLOCKS));
  assign out_free  = !m_tvalid || m_tready;

  // next state and handshakes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            K_ALLOC: state_next = (head[IDX_W] || free_total == 9'd0) ? S_DONE : S_ALLOC;
            K_FREE:  state_next = out_range ? S_DONE : S_DIV;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ALLOC:     state_next = S_ADDR;
      S_ADDR:      state_next = S_DONE;
      S_DIV: begin
        if (div_k == 3'd0) state_next = (rem_nx != '0) ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (walk_end) state_next = S_PUSH;
        else if (cur[IDX_W-1:0] == work_idx) state_next = S_DONE;
        else state_next = S_WALK_WAIT;
      end
      S_WALK_WAIT: state_next = S_WALK;
      S_PUSH: begin
        ram_we     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // free list control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      free_total <= COUNT_RST;
      written    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // result register: loaded in done, cleared once taken
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (rethr.valid) begin
        head       <= '0;
        free_total <= rethr.count;
        written    <= '0;
      end
      case (state)
        S_ALLOC: begin
          head       <= link_rd;
          free_total <= free_total - 9'd1;
        end
        S_PUSH: begin
          head               <= LINK_W'(work_idx);
          free_total         <= free_total + 9'd1;
          written[work_idx]  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    case (state)
      S_IDLE: begin
        res_addr <= '0;
        work_idx <= head[IDX_W-1:0];
        rem      <= SPAN_W'(q_item.address - geom.base);
        div_k    <= 3'd7;
        case (q_item.kind)
          K_ALLOC: res_status <= (head[IDX_W] || free_total == 9'd0) ? ST_EXHAUSTED : ST_OK;
          K_FREE:  res_status <= out_range ? ST_RANGE : ST_OK;
          default: res_status <= ST_NULL;
        endcase
      end
      S_ALLOC: prod <= 26'(work_idx) * 26'(geom.size);
      S_ADDR:  res_addr <= geom.base + 32'(prod);
      S_DIV: begin
        rem                <= rem_nx;
        work_idx[div_k]    <= ge;
        div_k              <= div_k - 3'd1;
        cur                <= head;
        steps              <= '0;
        if (div_k == 3'd0 && rem_nx != '0) res_status <= ST_MISALIGN;
      end
      S_WALK: begin
        if (!walk_end && cur[IDX_W-1:0] == work_idx) res_status <= ST_DOUBLE;
      end
      S_WALK_WAIT: begin
        cur   <= link_rd;
        steps <= steps + 9'd1;
      end
      S_DONE: begin
        if (out_free) m_tdata <= {4'd0, free_total, res_addr, res_status};
      end
      default: ;
    endcase
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= geom.count) else $error("free count above pool size");
  a_head_total: assert property (@(posedge clk) disable iff (rst)
    head[IDX_W] == (free_total == 9'd0)) else $error("list head and free count disagree");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < geom.span) else $error("offset outside pool in division");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH && !rethr.valid |=> free_total == $past(free_total) + 9'd1)
    else $error("push did not raise free count");

endmodule

// ===== design/fixed_block_pool_allocator.sv =====
// fixed-size block pool allocator with a lifo free list
// input channel s_*: tuser[0] is the action (0 allocate, 1 free), tdata is the
// byte address to free. each request gives exactly one result on m_*: status,
// allocated block address and the free block count after the request.
// configuration channel cfg_*: index 0 base address, 1 block size, 2 block count;
// any write to a known index re-threads the whole pool as free in order.
// write configuration only while the block is idle.
// an allocate pops the list head and forms its address from the index, block
// size and base; a null or out-of-range free goes straight to the result; any
// other free runs a restoring division of its offset by the block size, and a
// misaligned one ends there. a free that passes walks the free list, a walk and
// a wait state per link for the registered link table read, and is pushed (at
// most 255 links) or found already free. one request is worked on at a time.
// a two-entry input queue keeps taking requests while one is worked on, and the
// result register holds its transaction while the receiver stalls.
// reset restores base 4096, block size 64, 256 blocks, all free; no clearing
// pass is needed since never-written links read as the threaded default.
module fixed_block_pool_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address
  input  logic [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status[2:0], block_address[34:3], free_blocks[43:35]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fbpa_pkg::*;

  logic [31:0]       base_address;
  logic [16:0]       blk_bytes;
  logic [8:0]        blk_num;
  logic [SPAN_W-1:0] span;
  logic              q_valid;
  logic              q_pop;
  item_t             q_item;
  geom_t             geom;
  rethread_t         rethr;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RST;
      blk_bytes    <= SIZE_RST;
      blk_num      <= COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_BASE:  base_address <= cfg_data;
        REG_SIZE:  blk_bytes    <= cfg_data[16:0];
        REG_COUNT: blk_num      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // pool length in bytes, registered
  always_ff @(posedge clk) begin
    span <= SPAN_W'(eff_count(blk_num)) * SPAN_W'(eff_size(blk_bytes));
  end

  always_comb begin
    geom.base  = base_address;
    geom.size  = eff_size(blk_bytes);
    geom.count = eff_count(blk_num);
    geom.span  = span;
    rethr.valid = cfg_wr && (cfg_index == REG_BASE || cfg_index == REG_SIZE ||
                             cfg_index == REG_COUNT);
    rethr.count = (cfg_index == REG_COUNT) ? eff_count(cfg_data[8:0]) : geom.count;
  end

  fbpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  fbpa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .geom     (geom),
    .rethr    (rethr),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
